FILE: src/mipsx_pkg.sv
// Shared types, sizes and instruction encodings for the MIPS32 execute unit.
package mipsx_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned NUM_REGS = 32;
  localparam int unsigned REG_IDXW = $clog2(NUM_REGS);
  localparam int unsigned OUT_W    = 40;

  // Major opcodes.
  localparam logic [5:0] OP_SPECIAL  = 6'h00;
  localparam logic [5:0] OP_ADDIU    = 6'h09;
  localparam logic [5:0] OP_SLTI     = 6'h0a;
  localparam logic [5:0] OP_SLTIU    = 6'h0b;
  localparam logic [5:0] OP_ANDI     = 6'h0c;
  localparam logic [5:0] OP_ORI      = 6'h0d;
  localparam logic [5:0] OP_XORI     = 6'h0e;
  localparam logic [5:0] OP_LUI      = 6'h0f;
  localparam logic [5:0] OP_SPECIAL2 = 6'h1c;
  localparam logic [5:0] OP_SPECIAL3 = 6'h1f;

  // SPECIAL function codes.
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_SLLV = 6'h04;
  localparam logic [5:0] FN_SRLV = 6'h06;
  localparam logic [5:0] FN_MOVZ = 6'h0a;
  localparam logic [5:0] FN_MOVN = 6'h0b;
  localparam logic [5:0] FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MTHI = 6'h11;
  localparam logic [5:0] FN_MFLO = 6'h12;
  localparam logic [5:0] FN_MTLO = 6'h13;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_SLT  = 6'h2a;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  // SPECIAL2 function codes.
  localparam logic [5:0] FN2_MUL = 6'h02;
  localparam logic [5:0] FN2_CLZ = 6'h20;
  localparam logic [5:0] FN2_CLO = 6'h21;

  // SPECIAL3 byte-shuffle function and its sub-codes in the sa field.
  localparam logic [5:0] FN3_BSHFL = 6'h20;
  localparam logic [4:0] SA_SEB    = 5'h10;
  localparam logic [4:0] SA_SEH    = 5'h18;

  // One general register write.
  typedef struct packed {
    logic                en;
    logic [REG_IDXW-1:0] idx;
    logic [XLEN-1:0]     val;
  } wr_t;

  // Everything the execute logic decides for one instruction.
  typedef struct packed {
    logic                wr_en;
    logic [REG_IDXW-1:0] wr_idx;
    logic [XLEN-1:0]     wr_val;
    logic                unsup;
    logic                hi_we;
    logic                lo_we;
  } exec_res_t;

endpackage

FILE: src/mipsx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mipsx_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/mipsx_regfile.sv
// General register file: two RAM copies for the rs and rt ports, valid bits and write bypass.
module mipsx_regfile (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [mipsx_pkg::REG_IDXW-1:0] rd_rs_addr,
  input  logic [mipsx_pkg::REG_IDXW-1:0] rd_rt_addr,
  input  logic [mipsx_pkg::REG_IDXW-1:0] ex_rs_idx,
  input  logic [mipsx_pkg::REG_IDXW-1:0] ex_rt_idx,
  output logic [mipsx_pkg::XLEN-1:0]     ex_rs_val,
  output logic [mipsx_pkg::XLEN-1:0]     ex_rt_val,
  input  mipsx_pkg::wr_t                 wr
);
  import mipsx_pkg::*;

  logic [XLEN-1:0]     rs_q;
  logic [XLEN-1:0]     rt_q;
  logic [NUM_REGS-1:0] vld_r;
  logic [NUM_REGS-1:0] vld_nxt;
  wr_t                 fwd_r;
  wr_t                 fwd_nxt;

  mipsx_ram #(.Width(XLEN), .Depth(NUM_REGS)) u_ram_rs (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.idx),
    .wdata (wr.val),
    .re    (rd_en),
    .raddr (rd_rs_addr),
    .rdata (rs_q)
  );

  mipsx_ram #(.Width(XLEN), .Depth(NUM_REGS)) u_ram_rt (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.idx),
    .wdata (wr.val),
    .re    (rd_en),
    .raddr (rd_rt_addr),
    .rdata (rt_q)
  );

  // The most recent write always holds the current value of its register, so it
  // covers the case where a read and a write to the same entry share a clock edge.
  always_comb begin
    vld_nxt = vld_r;
    fwd_nxt = fwd_r;
    if (wr.en) begin
      vld_nxt[wr.idx] = 1'b1;
      fwd_nxt         = wr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      fwd_r.en  <= 1'b0;
      fwd_r.idx <= '0;
      fwd_r.val <= '0;
    end else begin
      vld_r <= vld_nxt;
      fwd_r <= fwd_nxt;
    end
  end

  // Entries never written since reset read as zero.
  assign ex_rs_val = (fwd_r.en && fwd_r.idx == ex_rs_idx) ? fwd_r.val :
                     (vld_r[ex_rs_idx] ? rs_q : '0);
  assign ex_rt_val = (fwd_r.en && fwd_r.idx == ex_rt_idx) ? fwd_r.val :
                     (vld_r[ex_rt_idx] ? rt_q : '0);

  a_zero_never_valid : assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0]) else $error("register zero marked as written");

  a_fwd_sets_valid : assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r.en |-> vld_r[fwd_r.idx]) else $error("bypassed register not marked valid");

  a_no_write_zero : assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> wr.idx != '0) else $error("write to register zero");

endmodule

FILE: src/mipsx_alu.sv
// Instruction decode and integer execute logic for one instruction.
module mipsx_alu (
  input  logic [mipsx_pkg::XLEN-1:0] instr,
  input  logic [mipsx_pkg::XLEN-1:0] vs,
  input  logic [mipsx_pkg::XLEN-1:0] vt,
  input  logic [mipsx_pkg::XLEN-1:0] hi,
  input  logic [mipsx_pkg::XLEN-1:0] lo,
  output mipsx_pkg::exec_res_t       res
);
  import mipsx_pkg::*;

  logic [5:0]          op;
  logic [4:0]          rt;
  logic [4:0]          rd;
  logic [4:0]          sa;
  logic [5:0]          fn;
  logic [15:0]         imm;
  logic [XLEN-1:0]     simm;
  logic [XLEN-1:0]     zimm;
  logic [XLEN-1:0]     prod;
  logic [2*XLEN-1:0]   rot_sa;
  logic [2*XLEN-1:0]   rot_vs;
  logic [XLEN-1:0]     sra_val;
  logic [XLEN-1:0]     clz_val;
  logic [XLEN-1:0]     clo_val;
  logic                wr;
  logic                bad;
  logic                hi_we;
  logic                lo_we;
  logic [4:0]          dst;
  logic [XLEN-1:0]     val;

  // Leading-zero count by five halving steps; an all-zero word gives 32.
  function automatic logic [XLEN-1:0] clz32(input logic [XLEN-1:0] x);
    logic [XLEN-1:0] v;
    logic [5:0]      n;
    v = x;
    n = '0;
    if (v[31:16] == '0) begin n = n + 6'd16; v = v << 16; end
    if (v[31:24] == '0) begin n = n + 6'd8;  v = v << 8;  end
    if (v[31:28] == '0) begin n = n + 6'd4;  v = v << 4;  end
    if (v[31:30] == '0) begin n = n + 6'd2;  v = v << 2;  end
    if (!v[31])         begin n = n + 6'd1;  v = v << 1;  end
    if (!v[31])         begin n = n + 6'd1;               end
    return {{(XLEN-6){1'b0}}, n};
  endfunction

  assign op   = instr[31:26];
  assign rt   = instr[20:16];
  assign rd   = instr[15:11];
  assign sa   = instr[10:6];
  assign fn   = instr[5:0];
  assign imm  = instr[15:0];
  assign simm = {{16{imm[15]}}, imm};
  assign zimm = {16'h0000, imm};

  assign prod    = vs * vt;
  assign rot_sa  = {vt, vt} >> sa;
  assign rot_vs  = {vt, vt} >> vs[4:0];
  assign sra_val = $signed(vt) >>> sa;
  assign clz_val = clz32(vs);
  assign clo_val = clz32(~vs);

  always_comb begin
    wr    = 1'b0;
    bad   = 1'b0;
    hi_we = 1'b0;
    lo_we = 1'b0;
    dst   = '0;
    val   = '0;
    case (op)
      OP_SPECIAL: begin
        dst = rd;
        wr  = 1'b1;
        case (fn)
          FN_SLL:  val = vt << sa;
          FN_SRL:  val = instr[21] ? rot_sa[XLEN-1:0] : (vt >> sa);
          FN_SRA:  val = sra_val;
          FN_SLLV: val = vt << vs[4:0];
          FN_SRLV: val = instr[6] ? rot_vs[XLEN-1:0] : (vt >> vs[4:0]);
          FN_MOVZ: begin wr = (vt == '0); val = vs; end
          FN_MOVN: begin wr = (vt != '0); val = vs; end
          FN_MFHI: val = hi;
          FN_MTHI: begin wr = 1'b0; hi_we = 1'b1; end
          FN_MFLO: val = lo;
          FN_MTLO: begin wr = 1'b0; lo_we = 1'b1; end
          FN_AND:  val = vs & vt;
          FN_OR:   val = vs | vt;
          FN_XOR:  val = vs ^ vt;
          FN_SLT:  val = {{(XLEN-1){1'b0}}, ($signed(vs) < $signed(vt))};
          FN_SLTU: val = {{(XLEN-1){1'b0}}, (vs < vt)};
          default: begin bad = 1'b1; wr = 1'b0; end
        endcase
      end
      OP_SPECIAL2: begin
        dst = rd;
        wr  = 1'b1;
        case (fn)
          FN2_MUL: val = prod;
          FN2_CLZ: val = clz_val;
          FN2_CLO: val = clo_val;
          default: begin bad = 1'b1; wr = 1'b0; end
        endcase
      end
      OP_SPECIAL3: begin
        dst = rd;
        if (fn == FN3_BSHFL && sa == SA_SEB) begin
          wr  = 1'b1;
          val = {{24{vt[7]}}, vt[7:0]};
        end else if (fn == FN3_BSHFL && sa == SA_SEH) begin
          wr  = 1'b1;
          val = {{16{vt[15]}}, vt[15:0]};
        end else begin
          bad = 1'b1;
        end
      end
      OP_ADDIU: begin dst = rt; wr = 1'b1; val = vs + simm; end
      OP_SLTI: begin
        dst = rt;
        wr  = 1'b1;
        val = {{(XLEN-1){1'b0}}, ($signed(vs) < $signed(simm))};
      end
      OP_SLTIU: begin dst = rt; wr = 1'b1; val = {{(XLEN-1){1'b0}}, (vs < simm)}; end
      OP_ANDI:  begin dst = rt; wr = 1'b1; val = vs & zimm; end
      OP_ORI:   begin dst = rt; wr = 1'b1; val = vs | zimm; end
      OP_XORI:  begin dst = rt; wr = 1'b1; val = vs ^ zimm; end
      OP_LUI:   begin dst = rt; wr = 1'b1; val = {imm, 16'h0000}; end
      default:  begin bad = 1'b1; end
    endcase

    // Writes to register zero are dropped and report nothing.
    res.wr_en  = wr && (dst != '0);
    res.wr_idx = res.wr_en ? dst : '0;
    res.wr_val = res.wr_en ? val : '0;
    res.unsup  = bad;
    res.hi_we  = hi_we;
    res.lo_we  = lo_we;
  end

endmodule

FILE: src/mips32_integer_execute_unit.sv
// Top level of the MIPS32 integer execute unit: input stage, execute, result register.
//
// Usage: each transfer on the in_ channel carries one 32-bit MIPS32 instruction word.
// The unit executes it against its own 32-entry general register file (register zero
// reads as zero) and the HI and LO words, and returns exactly one result transfer on
// the out_ channel, in order: the register write it performed (enable, index, value)
// and a flag for encodings it does not implement, which change no state.
// An instruction taken from the in_ channel is read from the register file at the edge
// that takes it and held in the input stage, executed there, and loaded into the result
// register once that register is empty or being drained; its result is then offered on
// the out_ channel.
// Throughput: one instruction per clock while out_tready stays high. A dependent
// instruction may follow directly; the most recent register write is bypassed around
// the register file RAM. The execute logic between the input stage and the result
// register is combinational and holds one 32x32 multiplier for MUL.
// Reset (rst_n low, synchronous) empties both stages, clears HI and LO, and marks every
// general register as zero through per-register valid bits; no clearing pass is needed.
// When the receiver stalls, the result register holds its transfer and the input stage
// still takes one more instruction; in_tready then drops until the result moves on.
module mips32_integer_execute_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [mipsx_pkg::XLEN-1:0]  in_tdata,   // [31:0] instruction_word
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [0] write_enable, [5:1] write_index, [37:6] write_value, [38] unsupported, [39] zero
  output logic [mipsx_pkg::OUT_W-1:0] out_tdata
);
  import mipsx_pkg::*;

  logic              in_xfer;
  logic              s1_adv;
  logic              s1_vld_r;
  logic              s1_vld_nxt;
  logic [XLEN-1:0]   s1_instr_r;
  logic              out_vld_r;
  logic              out_vld_nxt;
  logic [OUT_W-1:0]  out_data_r;
  logic [XLEN-1:0]   hi_r;
  logic [XLEN-1:0]   lo_r;
  logic [XLEN-1:0]   rs_val;
  logic [XLEN-1:0]   rt_val;
  exec_res_t         res;
  wr_t               rf_wr;

  // The execute stage moves on whenever the result register is empty or being drained.
  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  // Register file reads are issued with the incoming instruction's rs and rt fields.
  mipsx_regfile u_regfile (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (in_xfer),
    .rd_rs_addr (in_tdata[25:21]),
    .rd_rt_addr (in_tdata[20:16]),
    .ex_rs_idx  (s1_instr_r[25:21]),
    .ex_rt_idx  (s1_instr_r[20:16]),
    .ex_rs_val  (rs_val),
    .ex_rt_val  (rt_val),
    .wr         (rf_wr)
  );

  mipsx_alu u_alu (
    .instr (s1_instr_r),
    .vs    (rs_val),
    .vt    (rt_val),
    .hi    (hi_r),
    .lo    (lo_r),
    .res   (res)
  );

  // State is committed at the same edge that loads the result register.
  assign rf_wr.en  = s1_adv && res.wr_en;
  assign rf_wr.idx = res.wr_idx;
  assign rf_wr.val = res.wr_val;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_xfer) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (s1_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      hi_r      <= '0;
      lo_r      <= '0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (s1_adv && res.hi_we) begin
        hi_r <= rs_val;
      end
      if (s1_adv && res.lo_we) begin
        lo_r <= rs_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_instr_r <= in_tdata;
    end
    if (s1_adv) begin
      out_data_r <= {1'b0, res.unsup, res.wr_val, res.wr_idx, res.wr_en};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_unsup_no_write : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && res.unsup |-> !res.wr_en && !res.hi_we && !res.lo_we)
    else $error("unsupported instruction changes state");

  a_adv_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_vld_r) else $error("executed instruction lost its result");

  a_hold_blocks_in : assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_adv |-> !in_tready) else $error("input taken over a held instruction");

  a_stall_keeps_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_adv |=> s1_vld_r && $stable(s1_instr_r))
    else $error("held instruction changed while stalled");

endmodule
